// ----- design/gnh_pkg.sv -----
// Shared types, codes and constants for the geographic next-hop selector.
// No dependencies; imported by gnh_cordic and the top level.
package gnh_pkg;

   localparam int NEIGHBOR_DEPTH_DEF = 16;
   localparam int FORBID_DEPTH_DEF   = 32;
   localparam int ANGLE_BITS_DEF     = 16;

   localparam logic [15:0] LIFETIME_RESET = 16'd2000;

   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_WIDTH = 59;
   localparam int VEC_WIDTH    = 25;

   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_DELETE  = 3'd1;
   localparam logic [2:0] OP_CLEAR   = 3'd2;
   localparam logic [2:0] OP_MARK    = 3'd3;
   localparam logic [2:0] OP_GREEDY  = 3'd4;
   localparam logic [2:0] OP_RECOVER = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NONE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ADD_RD, S_ADD_EV, S_ADD_WR,
      S_DEL_RD, S_DEL_EV,
      S_MRK_RD, S_MRK_EV, S_MRK_WR,
      S_PN_RD, S_PN_EV, S_PF_RD, S_PF_EV,
      S_REF_W,
      S_D1, S_D2, S_D3,
      S_M_RD, S_M_EV, S_F_RD, S_F_EV,
      S_ANG_W, S_R_EV, S_G_EV, S_M_NX,
      S_FIN, S_OUT
   } state_type;

   // atan(2^-i) in 2^-32 turn
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      case (i)
         5'd0:    atan_turn = 32'h20000000;
         5'd1:    atan_turn = 32'h12E4051E;
         5'd2:    atan_turn = 32'h09FB385B;
         5'd3:    atan_turn = 32'h051111D4;
         5'd4:    atan_turn = 32'h028B0D43;
         5'd5:    atan_turn = 32'h0145D7E1;
         5'd6:    atan_turn = 32'h00A2F61E;
         5'd7:    atan_turn = 32'h00517C55;
         5'd8:    atan_turn = 32'h0028BE53;
         5'd9:    atan_turn = 32'h00145F2F;
         5'd10:   atan_turn = 32'h000A2F98;
         5'd11:   atan_turn = 32'h000517CC;
         5'd12:   atan_turn = 32'h00028BE6;
         5'd13:   atan_turn = 32'h000145F3;
         5'd14:   atan_turn = 32'h0000A2F9;
         5'd15:   atan_turn = 32'h0000517C;
         5'd16:   atan_turn = 32'h000028BE;
         5'd17:   atan_turn = 32'h0000145F;
         5'd18:   atan_turn = 32'h00000A2F;
         5'd19:   atan_turn = 32'h00000517;
         5'd20:   atan_turn = 32'h0000028B;
         5'd21:   atan_turn = 32'h00000145;
         5'd22:   atan_turn = 32'h000000A2;
         5'd23:   atan_turn = 32'h00000051;
         5'd24:   atan_turn = 32'h00000028;
         5'd25:   atan_turn = 32'h00000014;
         5'd26:   atan_turn = 32'h0000000A;
         5'd27:   atan_turn = 32'h00000005;
         5'd28:   atan_turn = 32'h00000002;
         5'd29:   atan_turn = 32'h00000001;
         default: atan_turn = 32'h00000000;
      endcase
   endfunction

endpackage

// ----- design/gnh_cordic.sv -----
// Iterative vectoring CORDIC: vector angle in 2^-32 turn, one step a cycle.
// Depends on gnh_pkg (step count, widths, arctangent table).
module gnh_cordic import gnh_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [VEC_WIDTH-1:0] vec_x,
   input  logic signed [VEC_WIDTH-1:0] vec_y,
   output logic                        busy,
   output logic                        done,
   output logic [31:0]                 angle
);

   logic signed [CORDIC_WIDTH-1:0] x_ff, x_in, y_ff, y_in, xs, ys, xi, yi;
   logic [31:0] z_ff, z_in;
   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in, done_ff, done_in;

   assign xi = $signed({{(CORDIC_WIDTH-VEC_WIDTH-30){vec_x[VEC_WIDTH-1]}}, vec_x, 30'b0});
   assign yi = $signed({{(CORDIC_WIDTH-VEC_WIDTH-30){vec_y[VEC_WIDTH-1]}}, vec_y, 30'b0});
   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         step_in = '0;
         busy_in = 1'b1;
         if (vec_x[VEC_WIDTH-1]) begin
            x_in = -xi;
            y_in = -yi;
            z_in = 32'h80000000;
         end else begin
            x_in = xi;
            y_in = yi;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_turn(step_ff);
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_turn(step_ff);
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy  = busy_ff;
   assign done  = done_ff;
   assign angle = z_ff;

endmodule

// ----- design/geographic_next_hop_selector.sv -----
// Geographic next-hop selector: aging neighbor and forbidden-pair tables, greedy and
// recovery selection. Depends on gnh_pkg and gnh_cordic.
// Add and delete scan the neighbor table and mark scans the forbidden table before the result;
// selects purge both tables, take the own distance (greedy) or reference angle (recovery), then
// per live neighbor scan the forbidden table and take its distance or angle. One item at a time.
// Reset (synchronous): both tables empty, lifetime 2000, no result pending.
module geographic_next_hop_selector import gnh_pkg::*; #(
   parameter int NEIGHBOR_DEPTH = NEIGHBOR_DEPTH_DEF,
   parameter int FORBID_DEPTH   = FORBID_DEPTH_DEF,
   parameter int ANGLE_BITS     = ANGLE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // now[31:0] addr[63:32] target_x[87:64] target_y[111:88] node_x[135:112]
   // node_y[159:136] key_a[191:160] key_b[223:192] key_flag[224], zero pad
   input  logic [231:0] req_tdata,
   // op[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // next_hop[31:0]
   output logic [31:0]  rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);

   localparam int NIW = $clog2(NEIGHBOR_DEPTH);
   localparam int FIW = $clog2(FORBID_DEPTH);

   typedef struct packed {
      logic [31:0]        addr;
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic [31:0]        stamp;
   } nbr_entry_type;

   typedef struct packed {
      logic [31:0] ka;
      logic [31:0] kb;
      logic        flag;
      logic [31:0] recv;
      logic [31:0] stamp;
   } frb_entry_type;

   function automatic logic expired(input logic [31:0] now, input logic [31:0] stamp,
                                    input logic [15:0] life);
      logic [31:0] age;
      age     = now - stamp;
      expired = age >= {16'b0, life};
   endfunction

   function automatic logic [23:0] abs_diff(input logic [23:0] a, input logic [23:0] b);
      logic [24:0] d;
      d = {a[23], a} - {b[23], b};
      abs_diff = d[24] ? 24'(-d) : d[23:0];
   endfunction

   nbr_entry_type nbr_mem [NEIGHBOR_DEPTH];
   frb_entry_type frb_mem [FORBID_DEPTH];
   nbr_entry_type nbr_rd_ff, nbr_wd;
   frb_entry_type frb_rd_ff, frb_wd;
   logic nbr_we, frb_we;
   logic [NIW-1:0] nbr_wa;
   logic [FIW-1:0] frb_wa;

   state_type state_ff, state_in;
   logic [NIW-1:0] nidx_ff, nidx_in, hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   logic [FIW-1:0] fidx_ff, fidx_in, fhit_ff, fhit_in, ffree_ff, ffree_in;
   logic hit_vld_ff, hit_vld_in, free_vld_ff, free_vld_in;
   logic [2:0]  op_ff, op_in;
   logic [31:0] now_ff, now_in, addr_ff, addr_in, ka_ff, ka_in, kb_ff, kb_in;
   logic [23:0] tx_ff, tx_in, ty_ff, ty_in, nx_ff, nx_in, ny_ff, ny_in;
   logic        flag_ff, flag_in;
   logic [15:0] life_ff, life_in;
   logic [NEIGHBOR_DEPTH-1:0] nvld_ff, nvld_in;
   logic [FORBID_DEPTH-1:0]   fvld_ff, fvld_in;
   logic [31:0] cur_addr_ff, cur_addr_in;
   logic [23:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic fs_ff, fs_in, ffl_ff, ffl_in;
   logic [23:0] dxa_ff, dxa_in, dya_ff, dya_in;
   logic [47:0] sq1_ff, sq1_in, sq2_ff, sq2_in;
   logic [48:0] dist_ff, dist_in, own_ff, own_in, sq_sum;
   logic own_phase_ff, own_phase_in;
   logic low_vld_ff, low_vld_in, low_forb_ff, low_forb_in;
   logic [31:0] low_addr_ff, low_addr_in;
   logic [48:0] low_d_ff, low_d_in, a_d_ff, a_d_in;
   logic flip_vld_ff, flip_vld_in, a_vld_ff, a_vld_in, r_vld_ff, r_vld_in;
   logic [31:0] flip_addr_ff, flip_addr_in, a_addr_ff, a_addr_in, r_addr_ff, r_addr_in;
   logic [ANGLE_BITS-1:0] r_ang_ff, r_ang_in, qref_ff, qref_in, ang_ff, ang_in;
   logic refok_ff, refok_in, qok_ff, qok_in;
   logic [31:0] hop_ff, hop_in, rsp_hop_ff, rsp_hop_in;
   logic [1:0]  status_ff, status_in, rsp_status_ff, rsp_status_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [23:0] mul_op;
   logic [47:0] mul_res;
   logic        cor_start, cor_busy, cor_done;
   logic [31:0] cor_angle;
   logic signed [VEC_WIDTH-1:0] cor_x, cor_y;
   logic n_last, f_last, use_a;
   logic [48:0] best_d;
   logic [31:0] best_addr;

   gnh_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .vec_x (cor_x),
      .vec_y (cor_y),
      .busy  (cor_busy),
      .done  (cor_done),
      .angle (cor_angle)
   );

   assign mul_op  = (state_ff == S_D1) ? dxa_ff : dya_ff;
   assign mul_res = mul_op * mul_op;
   assign sq_sum  = {1'b0, sq1_ff} + {1'b0, sq2_ff};
   assign n_last  = nidx_ff == NIW'(NEIGHBOR_DEPTH - 1);
   assign f_last  = fidx_ff == FIW'(FORBID_DEPTH - 1);
   assign use_a     = a_vld_ff && (a_d_ff < low_d_ff);
   assign best_d    = use_a ? a_d_ff : low_d_ff;
   assign best_addr = use_a ? a_addr_ff : low_addr_ff;

   always_comb begin
      state_in = state_ff;
      nidx_in = nidx_ff; fidx_in = fidx_ff;
      hit_idx_in = hit_idx_ff; free_idx_in = free_idx_ff;
      hit_vld_in = hit_vld_ff; free_vld_in = free_vld_ff;
      fhit_in = fhit_ff; ffree_in = ffree_ff;
      op_in = op_ff; now_in = now_ff; addr_in = addr_ff; ka_in = ka_ff; kb_in = kb_ff;
      tx_in = tx_ff; ty_in = ty_ff; nx_in = nx_ff; ny_in = ny_ff; flag_in = flag_ff;
      life_in = csr_wr_en ? csr_wr_data : life_ff;
      nvld_in = nvld_ff; fvld_in = fvld_ff;
      cur_addr_in = cur_addr_ff; cur_x_in = cur_x_ff; cur_y_in = cur_y_ff;
      fs_in = fs_ff; ffl_in = ffl_ff;
      dxa_in = dxa_ff; dya_in = dya_ff; sq1_in = sq1_ff; sq2_in = sq2_ff;
      dist_in = dist_ff; own_in = own_ff; own_phase_in = own_phase_ff;
      low_vld_in = low_vld_ff; low_forb_in = low_forb_ff; low_addr_in = low_addr_ff;
      low_d_in = low_d_ff; a_d_in = a_d_ff; a_vld_in = a_vld_ff; a_addr_in = a_addr_ff;
      flip_vld_in = flip_vld_ff; flip_addr_in = flip_addr_ff;
      r_vld_in = r_vld_ff; r_addr_in = r_addr_ff; r_ang_in = r_ang_ff;
      qref_in = qref_ff; ang_in = ang_ff; refok_in = refok_ff; qok_in = qok_ff;
      hop_in = hop_ff; status_in = status_ff;
      rsp_hop_in = rsp_hop_ff; rsp_status_in = rsp_status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      nbr_we = 1'b0; nbr_wa = hit_vld_ff ? hit_idx_ff : free_idx_ff;
      nbr_wd = '{addr: addr_ff, x: tx_ff, y: ty_ff, stamp: now_ff};
      frb_we = 1'b0; frb_wa = fhit_ff;
      if (!hit_vld_ff) frb_wa = ffree_ff;
      frb_wd = '{ka: ka_ff, kb: kb_ff, flag: flag_ff, recv: addr_ff, stamp: now_ff};
      cor_start = 1'b0;
      cor_x = $signed({cur_x_ff[23], cur_x_ff} - {nx_ff[23], nx_ff});
      cor_y = $signed({cur_y_ff[23], cur_y_ff} - {ny_ff[23], ny_ff});

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in   = req_tuser;
               now_in  = req_tdata[31:0];
               addr_in = req_tdata[63:32];
               tx_in   = req_tdata[87:64];
               ty_in   = req_tdata[111:88];
               nx_in   = req_tdata[135:112];
               ny_in   = req_tdata[159:136];
               ka_in   = req_tdata[191:160];
               kb_in   = req_tdata[223:192];
               flag_in = req_tdata[224];
               nidx_in = '0; fidx_in = '0;
               hit_vld_in = 1'b0; free_vld_in = 1'b0;
               low_vld_in = 1'b0; flip_vld_in = 1'b0; a_vld_in = 1'b0; r_vld_in = 1'b0;
               hop_in = '0; status_in = ST_OK;
               case (req_tuser)
                  OP_ADD:     state_in = (req_tdata[63:32] != 32'd0) ? S_ADD_RD : S_OUT;
                  OP_DELETE:  state_in = S_DEL_RD;
                  OP_CLEAR: begin
                     nvld_in  = '0;
                     state_in = S_OUT;
                  end
                  OP_MARK:    state_in = S_MRK_RD;
                  OP_GREEDY:  state_in = S_PN_RD;
                  OP_RECOVER: state_in = S_PN_RD;
                  default:    state_in = S_OUT;
               endcase
            end
         end
         S_ADD_RD: state_in = S_ADD_EV;
         S_ADD_EV: begin
            if (nvld_ff[nidx_ff] && nbr_rd_ff.addr == addr_ff) begin
               hit_vld_in = 1'b1; hit_idx_in = nidx_ff;
            end else if (!nvld_ff[nidx_ff] && !free_vld_ff) begin
               free_vld_in = 1'b1; free_idx_in = nidx_ff;
            end
            nidx_in  = nidx_ff + NIW'(1);
            state_in = n_last ? S_ADD_WR : S_ADD_RD;
         end
         S_ADD_WR: begin
            if (hit_vld_ff || free_vld_ff) begin
               nbr_we = 1'b1;
               nvld_in[nbr_wa] = 1'b1;
            end else begin
               status_in = ST_FULL;
            end
            state_in = S_OUT;
         end
         S_DEL_RD: state_in = S_DEL_EV;
         S_DEL_EV: begin
            if (nvld_ff[nidx_ff] && nbr_rd_ff.addr == addr_ff) nvld_in[nidx_ff] = 1'b0;
            nidx_in  = nidx_ff + NIW'(1);
            state_in = n_last ? S_OUT : S_DEL_RD;
         end
         S_MRK_RD: state_in = S_MRK_EV;
         S_MRK_EV: begin
            if (fvld_ff[fidx_ff] && frb_rd_ff.ka == ka_ff && frb_rd_ff.kb == kb_ff &&
                frb_rd_ff.flag == flag_ff && frb_rd_ff.recv == addr_ff) begin
               hit_vld_in = 1'b1; fhit_in = fidx_ff;
            end else if (!fvld_ff[fidx_ff] && !free_vld_ff) begin
               free_vld_in = 1'b1; ffree_in = fidx_ff;
            end
            fidx_in  = fidx_ff + FIW'(1);
            state_in = f_last ? S_MRK_WR : S_MRK_RD;
         end
         S_MRK_WR: begin
            if (hit_vld_ff || free_vld_ff) begin
               frb_we = 1'b1;
               fvld_in[frb_wa] = 1'b1;
            end else begin
               status_in = ST_FULL;
            end
            state_in = S_OUT;
         end
         S_PN_RD: state_in = S_PN_EV;
         S_PN_EV: begin
            if (nvld_ff[nidx_ff] && expired(now_ff, nbr_rd_ff.stamp, life_ff))
               nvld_in[nidx_ff] = 1'b0;
            nidx_in  = nidx_ff + NIW'(1);
            state_in = n_last ? S_PF_RD : S_PN_RD;
         end
         S_PF_RD: state_in = S_PF_EV;
         S_PF_EV: begin
            if (fvld_ff[fidx_ff] && expired(now_ff, frb_rd_ff.stamp, life_ff))
               fvld_in[fidx_ff] = 1'b0;
            fidx_in = fidx_ff + FIW'(1);
            if (f_last) begin
               nidx_in = '0;
               if (op_ff == OP_GREEDY) begin
                  dxa_in = abs_diff(nx_ff, tx_ff);
                  dya_in = abs_diff(ny_ff, ty_ff);
                  own_phase_in = 1'b1;
                  state_in = S_D1;
               end else begin
                  refok_in = (tx_ff != nx_ff) || (ty_ff != ny_ff);
                  if ((tx_ff != nx_ff) || (ty_ff != ny_ff)) begin
                     cor_start = 1'b1;
                     cor_x = $signed({tx_ff[23], tx_ff} - {nx_ff[23], nx_ff});
                     cor_y = $signed({ty_ff[23], ty_ff} - {ny_ff[23], ny_ff});
                     state_in = S_REF_W;
                  end else begin
                     state_in = S_M_RD;
                  end
               end
            end else begin
               state_in = S_PF_RD;
            end
         end
         S_REF_W: begin
            if (cor_done) begin
               qref_in  = cor_angle[31 -: ANGLE_BITS];
               state_in = S_M_RD;
            end
         end
         S_D1: begin
            sq1_in = mul_res; state_in = S_D2;
         end
         S_D2: begin
            sq2_in = mul_res; state_in = S_D3;
         end
         S_D3: begin
            if (own_phase_ff) begin
               own_in = sq_sum; own_phase_in = 1'b0; state_in = S_M_RD;
            end else begin
               dist_in = sq_sum; state_in = S_G_EV;
            end
         end
         S_M_RD: state_in = S_M_EV;
         S_M_EV: begin
            if (nvld_ff[nidx_ff]) begin
               cur_addr_in = nbr_rd_ff.addr;
               cur_x_in = nbr_rd_ff.x;
               cur_y_in = nbr_rd_ff.y;
               fs_in = 1'b0; ffl_in = 1'b0; fidx_in = '0;
               state_in = S_F_RD;
            end else begin
               state_in = S_M_NX;
            end
         end
         S_F_RD: state_in = S_F_EV;
         S_F_EV: begin
            if (fvld_ff[fidx_ff] && frb_rd_ff.ka == ka_ff && frb_rd_ff.kb == kb_ff &&
                frb_rd_ff.recv == cur_addr_ff) begin
               if (frb_rd_ff.flag == flag_ff) fs_in = 1'b1;
               else ffl_in = 1'b1;
            end
            fidx_in = fidx_ff + FIW'(1);
            if (!f_last) begin
               state_in = S_F_RD;
            end else if (op_ff == OP_GREEDY) begin
               dxa_in = abs_diff(cur_x_ff, tx_ff);
               dya_in = abs_diff(cur_y_ff, ty_ff);
               state_in = S_D1;
            end else begin
               qok_in = refok_ff && ((cur_x_ff != nx_ff) || (cur_y_ff != ny_ff));
               if (refok_ff && ((cur_x_ff != nx_ff) || (cur_y_ff != ny_ff))) begin
                  cor_start = 1'b1;
                  state_in = S_ANG_W;
               end else begin
                  state_in = S_R_EV;
               end
            end
         end
         S_ANG_W: begin
            if (cor_done) begin
               ang_in   = qref_ff - cor_angle[31 -: ANGLE_BITS];
               state_in = S_R_EV;
            end
         end
         S_R_EV: begin
            if (!low_vld_ff || cur_addr_ff < low_addr_ff) begin
               low_vld_in = 1'b1; low_addr_in = cur_addr_ff;
            end
            if (qok_ff && ang_ff != '0 && !fs_ff &&
                (!r_vld_ff || ang_ff < r_ang_ff ||
                 (ang_ff == r_ang_ff && cur_addr_ff < r_addr_ff))) begin
               r_vld_in = 1'b1; r_ang_in = ang_ff; r_addr_in = cur_addr_ff;
            end
            state_in = S_M_NX;
         end
         S_G_EV: begin
            if (!low_vld_ff || cur_addr_ff < low_addr_ff) begin
               low_vld_in = 1'b1; low_addr_in = cur_addr_ff;
               low_d_in = dist_ff; low_forb_in = fs_ff;
            end
            if (ffl_ff && (!flip_vld_ff || cur_addr_ff < flip_addr_ff)) begin
               flip_vld_in = 1'b1; flip_addr_in = cur_addr_ff;
            end
            if (!fs_ff && (!a_vld_ff || dist_ff < a_d_ff ||
                           (dist_ff == a_d_ff && cur_addr_ff < a_addr_ff))) begin
               a_vld_in = 1'b1; a_d_in = dist_ff; a_addr_in = cur_addr_ff;
            end
            state_in = S_M_NX;
         end
         S_M_NX: begin
            nidx_in  = nidx_ff + NIW'(1);
            state_in = n_last ? S_FIN : S_M_RD;
         end
         S_FIN: begin
            if (!low_vld_ff) begin
               status_in = ST_NONE;
            end else if (op_ff == OP_GREEDY) begin
               if (flip_vld_ff) hop_in = flip_addr_ff;
               else if (own_ff > best_d && (use_a || !low_forb_ff)) hop_in = best_addr;
               else status_in = ST_NONE;
            end else begin
               hop_in = r_vld_ff ? r_addr_ff : low_addr_ff;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_hop_in    = hop_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (nbr_we) nbr_mem[nbr_wa] <= nbr_wd;
      nbr_rd_ff <= nbr_mem[nidx_ff];
   end

   always_ff @(posedge clock) begin
      if (frb_we) frb_mem[frb_wa] <= frb_wd;
      frb_rd_ff <= frb_mem[fidx_ff];
   end

   always_ff @(posedge clock) begin
      nidx_ff <= nidx_in; fidx_ff <= fidx_in;
      hit_idx_ff <= hit_idx_in; free_idx_ff <= free_idx_in;
      hit_vld_ff <= hit_vld_in; free_vld_ff <= free_vld_in;
      fhit_ff <= fhit_in; ffree_ff <= ffree_in;
      op_ff <= op_in; now_ff <= now_in; addr_ff <= addr_in; ka_ff <= ka_in; kb_ff <= kb_in;
      tx_ff <= tx_in; ty_ff <= ty_in; nx_ff <= nx_in; ny_ff <= ny_in; flag_ff <= flag_in;
      cur_addr_ff <= cur_addr_in; cur_x_ff <= cur_x_in; cur_y_ff <= cur_y_in;
      fs_ff <= fs_in; ffl_ff <= ffl_in;
      dxa_ff <= dxa_in; dya_ff <= dya_in; sq1_ff <= sq1_in; sq2_ff <= sq2_in;
      dist_ff <= dist_in; own_ff <= own_in; own_phase_ff <= own_phase_in;
      low_vld_ff <= low_vld_in; low_forb_ff <= low_forb_in; low_addr_ff <= low_addr_in;
      low_d_ff <= low_d_in; a_d_ff <= a_d_in; a_vld_ff <= a_vld_in; a_addr_ff <= a_addr_in;
      flip_vld_ff <= flip_vld_in; flip_addr_ff <= flip_addr_in;
      r_vld_ff <= r_vld_in; r_addr_ff <= r_addr_in; r_ang_ff <= r_ang_in;
      qref_ff <= qref_in; ang_ff <= ang_in; refok_ff <= refok_in; qok_ff <= qok_in;
      hop_ff <= hop_in; status_ff <= status_in;
      rsp_hop_ff <= rsp_hop_in; rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         life_ff      <= LIFETIME_RESET;
         nvld_ff      <= '0;
         fvld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         life_ff      <= life_in;
         nvld_ff      <= nvld_in;
         fvld_ff      <= fvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_hop_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_ready_unit_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cor_busy)
      else $error("item taken while angle unit busy");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_CLEAR) |=> nvld_ff == '0)
      else $error("clear left neighbor entries valid");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == S_REF_W || state_ff == S_ANG_W))
      else $error("angle result outside a wait state");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff)
      else $error("result not presented");

endmodule
